// ===== rtl/core/bdm_serial_command_master_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BDM_SERIAL_COMMAND_MASTER_DEFINES_SVH
`define BDM_SERIAL_COMMAND_MASTER_DEFINES_SVH

// Implication checked at every rising edge, held off during reset.
`define BDM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define BDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bdm_pkg.sv =====
`default_nettype none

package bdm_pkg;

    localparam int WORD_BITS = 16;
    localparam int SLOT_W    = $clog2(WORD_BITS + 1);
    localparam int LONG_BIT  = 7;

    localparam logic [1:0] OPC_START_WR = 2'd0;
    localparam logic [1:0] OPC_START_RD = 2'd1;
    localparam logic [1:0] OPC_SLOT     = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/bdm_serial_command_master.sv =====
// Background debug serial command master.
// Input channel (in_valid / in_stall): one word per item. An opcode of start
// write or start read latches the command, address and data words; an opcode
// of bit slot drives one data-in bit and takes the sampled data-out bit.
// A frame is one status slot followed by 16 data slots sent MSB first.
// Output channel (out_valid / out_stall): exactly one result word per item,
// carrying the driven bit, busy flag, start rejection, completion flag, the
// 32-bit read result on the completing slot and the latest frame status.
// out_valid is registered: it rises in the cycle after acceptance.
// Throughput: one item per clock unless stalled; the sequencer state and frame
// shifters update on accept and the result sits in a single output register.
// While the output register holds a result that is stalled, in_stall is
// raised and no item is taken; the result and state hold until it drains.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, clears the
// slot counter, frame words and latches, and empties the output register.
// A start that arrives while a sequence runs is ignored and flagged.
`default_nettype none

module bdm_serial_command_master (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] command_word,
    input  wire logic [15:0] address_high,
    input  wire logic [15:0] address_low,
    input  wire logic [15:0] data_high,
    input  wire logic [15:0] data_low,
    input  wire logic        dso_sample,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             dsi_drive,
    output logic             busy_res,
    output logic             start_rejected,
    output logic             command_done,
    output logic [31:0]      read_data,
    output logic             last_status
);

    localparam int WB = bdm_pkg::WORD_BITS;
    localparam int SW = bdm_pkg::SLOT_W;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_CMD     = 8'b0000_0010,
        PH_ADDR_HI = 8'b0000_0100,
        PH_ADDR_LO = 8'b0000_1000,
        PH_DATA_HI = 8'b0001_0000,
        PH_DATA_LO = 8'b0010_0000,
        PH_POLL_HI = 8'b0100_0000,
        PH_POLL    = 8'b1000_0000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [WB-1:0]       out_word_reg, out_word_next;
    logic [WB-1:0]       in_word_reg, in_word_next;
    logic                status_reg, status_next;
    logic [WB-1:0]       cmd_reg, cmd_next;
    logic [2*WB-1:0]     addr_reg, addr_next;
    logic [2*WB-1:0]     data_reg, data_next;
    logic [WB-1:0]       rd_high_reg, rd_high_next;
    logic                is_read_reg, is_read_next;

    logic                out_valid_reg, out_valid_next;
    logic                dsi_reg, dsi_next;
    logic                busy_reg, busy_next;
    logic                rejected_reg, rejected_next;
    logic                done_reg, done_next;
    logic [31:0]         rdata_reg, rdata_next;

    logic                in_accept;
    logic                is_start;
    logic                long_op;
    phase_t              after_addr;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign is_start  = (opcode == bdm_pkg::OPC_START_WR) || (opcode == bdm_pkg::OPC_START_RD);
    assign long_op   = cmd_reg[bdm_pkg::LONG_BIT];

    always_comb
    begin
        if (is_read_reg)
            after_addr = long_op ? PH_POLL_HI : PH_POLL;
        else
            after_addr = long_op ? PH_DATA_HI : PH_DATA_LO;
    end

    // Word loaded into the transmit shifter on entry to a phase.
    function automatic logic [WB-1:0] load_word(input phase_t ph,
                                                 input logic [2*WB-1:0] addr,
                                                 input logic [2*WB-1:0] data);
        logic [WB-1:0] w;
        begin
            unique case (ph)
                PH_ADDR_HI: w = addr[2*WB-1:WB];
                PH_ADDR_LO: w = addr[WB-1:0];
                PH_DATA_HI: w = data[2*WB-1:WB];
                PH_DATA_LO: w = data[WB-1:0];
                default:    w = '0;
            endcase
            return w;
        end
    endfunction

    always_comb
    begin
        phase_t nph;

        phase_next    = phase_reg;
        slot_next     = slot_reg;
        out_word_next = out_word_reg;
        in_word_next  = in_word_reg;
        status_next   = status_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        data_next     = data_reg;
        rd_high_next  = rd_high_reg;
        is_read_next  = is_read_reg;
        dsi_next      = 1'b0;
        rejected_next = 1'b0;
        done_next     = 1'b0;
        rdata_next    = '0;
        nph           = phase_reg;

        if (in_accept) begin
            if (is_start) begin
                if (phase_reg != PH_IDLE) begin
                    rejected_next = 1'b1;
                end else begin
                    cmd_next      = command_word[WB-1:0];
                    addr_next     = {address_high[WB-1:0], address_low[WB-1:0]};
                    data_next     = {data_high[WB-1:0], data_low[WB-1:0]};
                    is_read_next  = (opcode == bdm_pkg::OPC_START_RD);
                    rd_high_next  = '0;
                    phase_next    = PH_CMD;
                    slot_next     = '0;
                    out_word_next = command_word[WB-1:0];
                end
            end else if (opcode == bdm_pkg::OPC_SLOT && phase_reg != PH_IDLE) begin
                if (slot_reg == '0) begin
                    // status slot: drive low, take the status bit
                    status_next = dso_sample;
                    slot_next   = SW'(1);
                end else begin
                    dsi_next      = out_word_reg[WB-1];
                    out_word_next = {out_word_reg[WB-2:0], 1'b0};
                    in_word_next  = {in_word_reg[WB-2:0], dso_sample};
                    if (slot_reg == SW'(WB)) begin
                        slot_next = '0;
                        unique case (phase_reg)
                            PH_CMD:     nph = (addr_reg != '0) ? PH_ADDR_HI : after_addr;
                            PH_ADDR_HI: nph = PH_ADDR_LO;
                            PH_ADDR_LO: nph = after_addr;
                            PH_DATA_HI: nph = PH_DATA_LO;
                            PH_DATA_LO: nph = PH_POLL;
                            PH_POLL_HI:
                            begin
                                if (!status_reg) begin
                                    rd_high_next = in_word_next;
                                    nph          = PH_POLL;
                                end
                            end
                            PH_POLL:
                            begin
                                if (!status_reg) begin
                                    done_next = 1'b1;
                                    if (is_read_reg)
                                        rdata_next = 32'({rd_high_reg, in_word_next});
                                    nph = PH_IDLE;
                                end
                            end
                            default: nph = phase_reg;
                        endcase
                        // a poll frame that is not ready keeps its zero word
                        if (nph != phase_reg || phase_reg == PH_CMD)
                            out_word_next = load_word(nph, addr_reg, data_reg);
                        phase_next = nph;
                    end else begin
                        slot_next = slot_reg + SW'(1);
                    end
                end
            end
        end

        busy_next = (phase_next != PH_IDLE);

        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            slot_reg      <= '0;
            out_word_reg  <= '0;
            in_word_reg   <= '0;
            status_reg    <= 1'b0;
            cmd_reg       <= '0;
            addr_reg      <= '0;
            data_reg      <= '0;
            rd_high_reg   <= '0;
            is_read_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            out_word_reg  <= out_word_next;
            in_word_reg   <= in_word_next;
            status_reg    <= status_next;
            cmd_reg       <= cmd_next;
            addr_reg      <= addr_next;
            data_reg      <= data_next;
            rd_high_reg   <= rd_high_next;
            is_read_reg   <= is_read_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            dsi_reg      <= dsi_next;
            busy_reg     <= busy_next;
            rejected_reg <= rejected_next;
            done_reg     <= done_next;
            rdata_reg    <= rdata_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dsi_drive      = dsi_reg;
    assign busy_res       = busy_reg;
    assign start_rejected = rejected_reg;
    assign command_done   = done_reg;
    assign read_data      = rdata_reg;
    assign last_status    = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bdm_checker.sv =====
`default_nettype none

`include "bdm_serial_command_master_defines.svh"

module bdm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        dsi_drive,
    input wire logic        busy_res,
    input wire logic        start_rejected,
    input wire logic        command_done,
    input wire logic [31:0] read_data
);

    `BDM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result word dropped")

    `BDM_ASSERT_IMPL(a_done_idle, out_valid && command_done, !busy_res && !start_rejected,
                     "completion reported while still busy or rejecting")

    `BDM_ASSERT_IMPL(a_reject_busy, out_valid && start_rejected, busy_res && !dsi_drive,
                     "start rejected while idle or with a driven bit")

    `BDM_ASSERT_IMPL(a_rdata_done, out_valid && !command_done, read_data == 32'd0,
                     "read data outside a completing slot")

endmodule

bind bdm_serial_command_master bdm_checker u_bdm_checker (.*);

`default_nettype wire
